@@ sv/pdec_pkg.sv @@
// Shared types, field widths, event codes and scaling constants for the
// pen digitizer event decoder. No dependencies; every other file uses it.
`default_nettype none

package pdec_pkg;

  localparam int unsigned SCREEN_WIDTH  = 1404;
  localparam int unsigned SCREEN_HEIGHT = 1872;

  localparam int unsigned LONG_MAX_RAW     = 20967;
  localparam int unsigned SHORT_MAX_RAW    = 15725;
  localparam int unsigned PRESSURE_MAX_RAW = 4095;
  localparam int unsigned COORD_LIMIT      = 2047;

  localparam int unsigned TYPE_W   = 5;
  localparam int unsigned CODE_W   = 10;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned LONG_W   = 15;
  localparam int unsigned SHORT_W  = 14;
  localparam int unsigned PRESS_W  = 12;
  localparam int unsigned COORD_W  = 11;
  localparam int unsigned RADIUS_W = 5;

  // Fixed-point reciprocal scaling: floor(x * M >> S) equals floor(x * N / D)
  // for every x up to D, since x * (M * D - N * 2^S) stays below 2^S.
  localparam int unsigned SCALE_X_SHIFT = 28;
  localparam int unsigned SCALE_Y_SHIFT = 29;
  localparam longint unsigned SCALE_X_MUL =
    ((longint'(SCREEN_WIDTH) << SCALE_X_SHIFT) + longint'(SHORT_MAX_RAW) - 1) /
    longint'(SHORT_MAX_RAW);
  localparam longint unsigned SCALE_Y_MUL =
    ((longint'(SCREEN_HEIGHT) << SCALE_Y_SHIFT) + longint'(LONG_MAX_RAW) - 1) /
    longint'(LONG_MAX_RAW);
  localparam int unsigned SCALE_X_W = $clog2(SCALE_X_MUL + 1);
  localparam int unsigned SCALE_Y_W = $clog2(SCALE_Y_MUL + 1);
  localparam int unsigned PROD_X_W  = SHORT_W + SCALE_X_W;
  localparam int unsigned PROD_Y_W  = LONG_W + SCALE_Y_W;
  localparam int unsigned QUOT_X_W  = PROD_X_W - SCALE_X_SHIFT;
  localparam int unsigned QUOT_Y_W  = PROD_Y_W - SCALE_Y_SHIFT;
  localparam int unsigned DIFF_W    = $clog2(SCREEN_HEIGHT + 1);

  typedef logic [LONG_W-1:0]   long_t;
  typedef logic [SHORT_W-1:0]  short_t;
  typedef logic [PRESS_W-1:0]  press_t;
  typedef logic [COORD_W-1:0]  coord_t;
  typedef logic [RADIUS_W-1:0] radius_t;
  typedef logic [PROD_X_W-1:0] prod_x_t;
  typedef logic [PROD_Y_W-1:0] prod_y_t;
  typedef logic [QUOT_X_W-1:0] quot_x_t;
  typedef logic [QUOT_Y_W-1:0] quot_y_t;
  typedef logic [DIFF_W-1:0]   diff_t;

  localparam logic [TYPE_W-1:0] EV_SYNC = 5'd0;
  localparam logic [TYPE_W-1:0] EV_KEY  = 5'd1;
  localparam logic [TYPE_W-1:0] EV_ABS  = 5'd3;

  localparam logic [CODE_W-1:0] AXIS_LONG       = 10'd0;
  localparam logic [CODE_W-1:0] AXIS_SHORT      = 10'd1;
  localparam logic [CODE_W-1:0] AXIS_PRESSURE   = 10'd24;
  localparam logic [CODE_W-1:0] KEY_TOOL_PEN    = 10'h140;
  localparam logic [CODE_W-1:0] KEY_TOOL_ERASER = 10'h141;
  localparam logic [CODE_W-1:0] KEY_TOUCH       = 10'h14a;

  localparam logic [RADIUS_W-1:0] RADIUS_ERASER = 5'd20;
  localparam logic [RADIUS_W-1:0] RADIUS_IDLE   = 5'd4;
  localparam logic [RADIUS_W-1:0] RADIUS_BASE   = 5'd2;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_PRESS   = 2'd1,
    ACT_MOVE    = 2'd2,
    ACT_RELEASE = 2'd3
  } action_e;

  typedef struct packed {
    logic [TYPE_W-1:0]         ev_type;
    logic [CODE_W-1:0]         code;
    logic signed [VALUE_W-1:0] value;
  } event_t;

  typedef struct packed {
    action_e  action;
    coord_t   pix_x;
    coord_t   pix_y;
    radius_t  brush_radius;
    logic     eraser_on;
    logic     pen_activity;
  } result_t;

endpackage

`default_nettype wire

@@ sv/pdec_in_reg.sv @@
// Input register stage: captures one event word per accepted handshake.
// Depends on pdec_pkg for the event record type.
`default_nettype none

module pdec_in_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pdec_pkg::event_t in_event_i,
  input  logic             advance_i,
  output logic             valid_o,
  output pdec_pkg::event_t event_o
);

  logic             valid_q, valid_d;
  pdec_pkg::event_t event_q;

  assign in_ready_o = !valid_q || advance_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      event_q <= in_event_i;
    end
  end

  assign valid_o = valid_q;
  assign event_o = event_q;

endmodule

`default_nettype wire

@@ sv/pdec_state.sv @@
// Pen state registers, event decode, coordinate scaling and brush radius.
// Depends on pdec_pkg for codes, scaling constants and record types.
`default_nettype none

module pdec_state (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_data_i,
  input  logic              fire_i,
  input  pdec_pkg::event_t  event_i,
  output pdec_pkg::result_t result_o
);

  function automatic pdec_pkg::long_t clamp_raw(input logic signed [31:0] v,
                                                input pdec_pkg::long_t hi);
    if (v < 0) begin
      return '0;
    end else if (v > $signed({17'b0, hi})) begin
      return hi;
    end
    return v[pdec_pkg::LONG_W-1:0];
  endfunction

  logic              dir_en_q;
  pdec_pkg::long_t   raw_long_q, raw_long_d;
  pdec_pkg::short_t  raw_short_q, raw_short_d;
  pdec_pkg::press_t  raw_press_q, raw_press_d;
  logic              eraser_q, eraser_d;
  logic              touch_now_q, touch_now_d;
  logic              touch_before_q, touch_before_d;

  pdec_pkg::prod_x_t prod_x;
  pdec_pkg::prod_y_t prod_y;
  pdec_pkg::quot_x_t quot_x;
  pdec_pkg::quot_y_t quot_y;
  pdec_pkg::diff_t   diff_y;
  pdec_pkg::coord_t  sat_x, sat_y;
  logic [14:0]       press_x5;
  logic              sync_en;
  logic              activity;
  pdec_pkg::action_e action;
  pdec_pkg::long_t   clamped;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_en_q <= 1'b1;
    end else if (cfg_valid_i) begin
      dir_en_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_long_q     <= '0;
      raw_short_q    <= '0;
      raw_press_q    <= '0;
      eraser_q       <= 1'b0;
      touch_now_q    <= 1'b0;
      touch_before_q <= 1'b0;
    end else if (fire_i) begin
      raw_long_q     <= raw_long_d;
      raw_short_q    <= raw_short_d;
      raw_press_q    <= raw_press_d;
      eraser_q       <= eraser_d;
      touch_now_q    <= touch_now_d;
      touch_before_q <= touch_before_d;
    end
  end

  // Scale to screen pixels; the vertical coordinate runs against the long axis.
  assign prod_x = pdec_pkg::prod_x_t'(raw_short_q) * pdec_pkg::prod_x_t'(pdec_pkg::SCALE_X_MUL);
  assign prod_y = pdec_pkg::prod_y_t'(raw_long_q) * pdec_pkg::prod_y_t'(pdec_pkg::SCALE_Y_MUL);
  assign quot_x = prod_x[pdec_pkg::PROD_X_W-1:pdec_pkg::SCALE_X_SHIFT];
  assign quot_y = prod_y[pdec_pkg::PROD_Y_W-1:pdec_pkg::SCALE_Y_SHIFT];
  assign diff_y = pdec_pkg::diff_t'(pdec_pkg::SCREEN_HEIGHT) - pdec_pkg::diff_t'(quot_y);
  assign sat_x  = (32'(quot_x) > pdec_pkg::COORD_LIMIT) ?
                  pdec_pkg::coord_t'(pdec_pkg::COORD_LIMIT) : pdec_pkg::coord_t'(quot_x);
  assign sat_y  = (32'(diff_y) > pdec_pkg::COORD_LIMIT) ?
                  pdec_pkg::coord_t'(pdec_pkg::COORD_LIMIT) : pdec_pkg::coord_t'(diff_y);

  always_comb begin
    raw_long_d     = raw_long_q;
    raw_short_d    = raw_short_q;
    raw_press_d    = raw_press_q;
    eraser_d       = eraser_q;
    touch_now_d    = touch_now_q;
    touch_before_d = touch_before_q;
    sync_en        = 1'b0;
    activity       = 1'b0;
    action         = pdec_pkg::ACT_NONE;
    clamped        = '0;
    unique case (event_i.ev_type)
      pdec_pkg::EV_ABS: begin
        unique case (event_i.code)
          pdec_pkg::AXIS_LONG: begin
            raw_long_d = clamp_raw(event_i.value, pdec_pkg::long_t'(pdec_pkg::LONG_MAX_RAW));
          end
          pdec_pkg::AXIS_SHORT: begin
            clamped     = clamp_raw(event_i.value, pdec_pkg::long_t'(pdec_pkg::SHORT_MAX_RAW));
            raw_short_d = pdec_pkg::short_t'(clamped);
          end
          pdec_pkg::AXIS_PRESSURE: begin
            clamped     = clamp_raw(event_i.value,
                                    pdec_pkg::long_t'(pdec_pkg::PRESSURE_MAX_RAW));
            raw_press_d = pdec_pkg::press_t'(clamped);
          end
          default: ;
        endcase
      end
      pdec_pkg::EV_KEY: begin
        unique case (event_i.code)
          pdec_pkg::KEY_TOOL_PEN: begin
            activity = 1'b1;
          end
          pdec_pkg::KEY_TOOL_ERASER: begin
            eraser_d = (event_i.value != '0);
            activity = 1'b1;
          end
          pdec_pkg::KEY_TOUCH: begin
            touch_now_d = (event_i.value != '0);
          end
          default: ;
        endcase
      end
      pdec_pkg::EV_SYNC: begin
        activity = 1'b1;
        if (dir_en_q) begin
          sync_en        = 1'b1;
          touch_before_d = touch_now_q;
          if (touch_now_q && !touch_before_q) begin
            action = pdec_pkg::ACT_PRESS;
          end else if (touch_now_q) begin
            action = pdec_pkg::ACT_MOVE;
          end else if (touch_before_q) begin
            action = pdec_pkg::ACT_RELEASE;
          end
        end
      end
      default: ;
    endcase
  end

  assign press_x5 = {3'b000, raw_press_d} + {1'b0, raw_press_d, 2'b00};

  always_comb begin
    result_o.action       = action;
    result_o.pix_x        = sync_en ? sat_x : '0;
    result_o.pix_y        = sync_en ? sat_y : '0;
    result_o.eraser_on    = eraser_d;
    result_o.pen_activity = activity;
    if (eraser_d) begin
      result_o.brush_radius = pdec_pkg::RADIUS_ERASER;
    end else if (raw_press_d != '0) begin
      result_o.brush_radius = pdec_pkg::RADIUS_BASE + {2'b00, press_x5[14:12]};
    end else begin
      result_o.brush_radius = pdec_pkg::RADIUS_IDLE;
    end
  end

endmodule

`default_nettype wire

@@ sv/pdec_out_reg.sv @@
// Result register stage: holds one result word until the receiver takes it.
// Depends on pdec_pkg for the result record type.
`default_nettype none

module pdec_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  pdec_pkg::result_t result_i,
  input  logic              out_ready_i,
  output logic              advance_o,
  output logic              out_valid_o,
  output pdec_pkg::result_t result_o
);

  logic              valid_q, valid_d;
  pdec_pkg::result_t result_q;

  assign advance_o = !valid_q || out_ready_i;
  assign valid_d   = advance_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && advance_o) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

@@ sv/pen_digitizer_event_decoder_top.sv @@
// Top level of the pen digitizer event decoder: input register, state and
// decode logic, result register. Depends on pdec_pkg and the pdec_* modules.
//
// Usage:
//   s_axis carries one input event word per handshake: tuser holds the event
//   type, tdata the code and the signed value. m_axis returns exactly one
//   result word per event: tuser holds the stroke action, tdata the screen
//   coordinates, brush radius, eraser flag and pen-activity flag.
//   cfg_valid_i/cfg_data_i write direct_enable; cfg_ready_o is always high.
//   Path: a word accepted on s_axis passes the input register, then the
//   result register, before it is presented on m_axis.
//   Throughput: one word per cycle while m_axis_tready is high; scaling uses
//   one 14x25 and one 15x26 multiplier between the two registers.
//   Reset clears the pen state to zero and sets direct_enable to 1; both
//   pipeline stages come up empty.
//   When m_axis_tready is low the result word holds, the input stage takes one
//   more word only if it is empty, and s_axis_tready then drops until the result moves.
`default_nettype none

module pen_digitizer_event_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // event_code[9:0], event_value[41:10], zero pad
  input  logic [4:0]  s_axis_tuser,  // event_type[4:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // pix_x[10:0], pix_y[21:11],
                                     // brush_radius[26:22], eraser_on[27],
                                     // pen_activity[28], zero pad
  output logic [1:0]  m_axis_tuser,  // action[1:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  pdec_pkg::event_t  in_event;
  pdec_pkg::event_t  stage_event;
  pdec_pkg::result_t stage_result;
  pdec_pkg::result_t out_result;
  logic              stage_valid;
  logic              advance;
  logic              fire;

  assign cfg_ready_o = 1'b1;

  assign in_event.ev_type = s_axis_tuser;
  assign in_event.code    = s_axis_tdata[9:0];
  assign in_event.value   = s_axis_tdata[41:10];

  pdec_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_event_i (in_event),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .event_o    (stage_event)
  );

  assign fire = stage_valid && advance;

  pdec_state u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (fire),
    .event_i     (stage_event),
    .result_o    (stage_result)
  );

  pdec_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (stage_valid),
    .result_i    (stage_result),
    .out_ready_i (m_axis_tready),
    .advance_o   (advance),
    .out_valid_o (m_axis_tvalid),
    .result_o    (out_result)
  );

  assign m_axis_tuser = out_result.action;
  assign m_axis_tdata = {3'b000, out_result.pen_activity, out_result.eraser_on,
                         out_result.brush_radius, out_result.pix_y,
                         out_result.pix_x};

  a_non_sync_no_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (stage_event.ev_type != pdec_pkg::EV_SYNC) |=>
      m_axis_tvalid && (m_axis_tuser == pdec_pkg::ACT_NONE))
    else $error("non-sync event produced a stroke action");

  a_sync_activity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (stage_event.ev_type == pdec_pkg::EV_SYNC) |=> m_axis_tvalid && m_axis_tdata[28])
    else $error("sync event did not flag pen activity");

  a_radius_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[26:22] >= 5'd2) && (m_axis_tdata[26:22] <= 5'd20))
    else $error("brush radius out of range");

  a_empty_out_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while result register empty");

endmodule

`default_nettype wire
